// ===== hdl/ddm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the differential drive mixer.
package ddm_pkg;

    localparam int SPEED_MAX = 100;

    localparam logic signed [7:0] SPEED_MAX_S = 8'(SPEED_MAX);
    localparam logic signed [9:0] SPEED_LIM   = 10'(SPEED_MAX);

    localparam logic [13:0] DUTY_FULL  = 14'd8192;
    // Multiplying by this and dropping 24 bits gives floor(x * 32 / 100) for x below 2^17.
    localparam logic [22:0] DUTY_RECIP = 23'd5368710;
    // Multiplying by this and dropping 11 bits gives floor(n / 10) for n below 1029.
    localparam logic [7:0]  RAMP_RECIP = 8'd205;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_JOY    = 2'd1;
    localparam logic [1:0] FUNC_DIRECT = 2'd2;

    localparam logic CFG_LEFT_GAIN  = 1'b0;
    localparam logic CFG_RIGHT_GAIN = 1'b1;

    typedef logic signed [7:0] speed_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic signed [7:0]  left_target;
        logic signed [7:0]  right_target;
    } cmd_t;

    typedef struct packed {
        speed_t left_vel;
        speed_t right_vel;
        logic   left_changed;
        logic   right_changed;
    } wheel_status_t;

    function automatic speed_t clamp_speed(input logic signed [9:0] v);
        speed_t r;
        if (v > SPEED_LIM)
        begin
            r = SPEED_MAX_S;
        end
        else if (v < -SPEED_LIM)
        begin
            r = -SPEED_MAX_S;
        end
        else
        begin
            r = 8'(v);
        end
        return r;
    endfunction

    // Scales a mixed Q15 axis sum to a speed, truncating toward zero.
    function automatic speed_t mix_axis(input logic signed [16:0] a);
        logic signed [24:0] p;
        logic [24:0]        mp;
        logic signed [9:0]  mag;
        logic signed [9:0]  q;
        p   = 25'(a) * 25'(SPEED_MAX_S);
        mp  = p[24] ? 25'(-p) : 25'(p);
        mag = $signed(mp[24:15]);
        q   = p[24] ? -mag : mag;
        return clamp_speed(q);
    endfunction

    // Moves the current speed one ramp step toward the goal.
    function automatic speed_t ramp_next(input speed_t goal, input speed_t cur);
        logic signed [8:0] d;
        logic [8:0]        n;
        logic [16:0]       prod;
        logic [4:0]        q;
        logic [4:0]        step;
        speed_t            r;
        d    = 9'(goal) - 9'(cur);
        n    = d[8] ? 9'(-d) : 9'(d);
        prod = 17'(n) * 17'(RAMP_RECIP);
        q    = prod[15:11];
        step = (q == 5'd0) ? 5'd1 : q;
        if (d == 9'sd0)
        begin
            r = cur;
        end
        else if (d[8])
        begin
            r = cur - 8'({3'b000, step});
        end
        else
        begin
            r = cur + 8'({3'b000, step});
        end
        return r;
    endfunction

endpackage

// ===== hdl/diff_drive_mix_ramp_hbridge_pwm.sv =====
// Top level of the two-wheel drive mixer with slew ramp and H-bridge duty outputs.
//
//  Channel   Signals                       Contents
//  s_*       tvalid tready tdata tuser     commands: tuser = func, tdata = stick and targets
//  m_*       tvalid tready tdata           tick results: duties, changed flags, speeds
//  cfg_*     we index data                 left_gain (index 0), right_gain (index 1)
//
// One transaction is accepted every cycle when the output side keeps up.
// A tick result reaches m_tdata through the input register, the ramp register, the gain
// product register and the output register. The two multiplications of the duty path
// set that depth. Commands update the targets in the ramp stage as they leave the input
// register and give no result. Reset clears the targets and speeds and sets both gains to 256.
// A stall on m_tready fills the four stages before s_tready drops.
module diff_drive_mix_ramp_hbridge_pwm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // stick_x, stick_y, left_target, right_target
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
    // left_changed, right_changed, left_speed_now, right_speed_now, zero fill
    output logic [79:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic in_valid_reg, in_valid_next;
    logic mid_valid_reg, mid_valid_next;
    logic prod_valid_reg, prod_valid_next;
    logic out_valid_reg, out_valid_next;

    ddm_pkg::cmd_t          cmd_reg, cmd_next;
    ddm_pkg::wheel_status_t mid_status;
    ddm_pkg::wheel_status_t prod_status_reg, prod_status_next;
    ddm_pkg::wheel_status_t out_status_reg, out_status_next;

    logic [8:0] left_gain_reg, left_gain_next;
    logic [8:0] right_gain_reg, right_gain_next;

    logic mid_ready;
    logic prod_ready;
    logic out_ready;
    logic advance;
    logic mul_en;
    logic out_en;

    logic [13:0] left_fwd;
    logic [13:0] left_rev;
    logic [13:0] right_fwd;
    logic [13:0] right_rev;

    assign out_ready  = !out_valid_reg || m_tready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign mid_ready  = !mid_valid_reg || prod_ready;
    assign s_tready   = !in_valid_reg || mid_ready;

    assign advance = in_valid_reg && mid_ready;
    assign mul_en  = mid_valid_reg && prod_ready;
    assign out_en  = prod_valid_reg && out_ready;

    always_comb
    begin
        in_valid_next   = s_tready ? s_tvalid : in_valid_reg;
        mid_valid_next  = mid_ready ? (advance && (cmd_reg.func == ddm_pkg::FUNC_TICK))
                                    : mid_valid_reg;
        prod_valid_next = prod_ready ? mid_valid_reg : prod_valid_reg;
        out_valid_next  = out_ready ? prod_valid_reg : out_valid_reg;

        cmd_next = cmd_reg;
        if (s_tvalid && s_tready)
        begin
            cmd_next.func         = s_tuser;
            cmd_next.stick_x      = s_tdata[15:0];
            cmd_next.stick_y      = s_tdata[31:16];
            cmd_next.left_target  = s_tdata[39:32];
            cmd_next.right_target = s_tdata[47:40];
        end

        prod_status_next = mul_en ? mid_status : prod_status_reg;
        out_status_next  = out_en ? prod_status_reg : out_status_reg;

        left_gain_next  = left_gain_reg;
        right_gain_next = right_gain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ddm_pkg::CFG_LEFT_GAIN:  left_gain_next  = cfg_data;
                ddm_pkg::CFG_RIGHT_GAIN: right_gain_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            mid_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_gain_reg  <= 9'd256;
            right_gain_reg <= 9'd256;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            mid_valid_reg  <= mid_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
            left_gain_reg  <= left_gain_next;
            right_gain_reg <= right_gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        prod_status_reg <= prod_status_next;
        out_status_reg  <= out_status_next;
    end

    ddm_ramp u_ramp (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (cmd_reg),
        .status  (mid_status)
    );

    ddm_duty u_left_duty (
        .clk      (clk),
        .mul_en   (mul_en),
        .out_en   (out_en),
        .speed    (mid_status.left_vel),
        .gain     (left_gain_reg),
        .fwd_duty (left_fwd),
        .rev_duty (left_rev)
    );

    ddm_duty u_right_duty (
        .clk      (clk),
        .mul_en   (mul_en),
        .out_en   (out_en),
        .speed    (mid_status.right_vel),
        .gain     (right_gain_reg),
        .fwd_duty (right_fwd),
        .rev_duty (right_rev)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_status_reg.right_vel,
                       out_status_reg.left_vel,
                       out_status_reg.right_changed,
                       out_status_reg.left_changed,
                       right_rev,
                       right_fwd,
                       left_rev,
                       left_fwd};

    // A result only appears when the product stage held a tick transaction.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(prod_valid_reg))
        else $error("result appeared without a tick in the product stage");

    // Commands update the targets and never reach the ramp register as a result.
    a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg.func != ddm_pkg::FUNC_TICK)) |=> !mid_valid_reg)
        else $error("command transaction produced a result");

    // Reported speeds stay within the speed limit.
    a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_status_reg.left_vel <= ddm_pkg::SPEED_MAX_S)
                  && (out_status_reg.left_vel >= -ddm_pkg::SPEED_MAX_S)
                  && (out_status_reg.right_vel <= ddm_pkg::SPEED_MAX_S)
                  && (out_status_reg.right_vel >= -ddm_pkg::SPEED_MAX_S))
        else $error("ramped speed outside the limit");

    // Only the channel of the speed's sign carries a duty.
    a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((left_fwd == 14'd0) || (left_rev == 14'd0))
                  && ((right_fwd == 14'd0) || (right_rev == 14'd0)))
        else $error("both bridge channels driven on one side");

endmodule

// ===== hdl/ddm_ramp.sv =====
// Target and current speed state, command decode and the slew ramp stage.
module ddm_ramp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  ddm_pkg::cmd_t          cmd,
    output ddm_pkg::wheel_status_t status
);

    ddm_pkg::speed_t left_goal_reg, left_goal_next;
    ddm_pkg::speed_t right_goal_reg, right_goal_next;
    ddm_pkg::speed_t left_cur_reg, left_cur_next;
    ddm_pkg::speed_t right_cur_reg, right_cur_next;
    ddm_pkg::wheel_status_t status_reg, status_next;

    logic signed [16:0] axis_sum;
    logic signed [16:0] axis_diff;
    ddm_pkg::speed_t    left_ramped;
    ddm_pkg::speed_t    right_ramped;

    assign axis_sum     = 17'(cmd.stick_y) + 17'(cmd.stick_x);
    assign axis_diff    = 17'(cmd.stick_y) - 17'(cmd.stick_x);
    assign left_ramped  = ddm_pkg::ramp_next(left_goal_reg, left_cur_reg);
    assign right_ramped = ddm_pkg::ramp_next(right_goal_reg, right_cur_reg);

    always_comb
    begin
        left_goal_next  = left_goal_reg;
        right_goal_next = right_goal_reg;
        left_cur_next   = left_cur_reg;
        right_cur_next  = right_cur_reg;
        status_next     = status_reg;
        if (advance)
        begin
            unique case (cmd.func)
                ddm_pkg::FUNC_TICK:
                begin
                    left_cur_next             = left_ramped;
                    right_cur_next            = right_ramped;
                    status_next.left_vel      = left_ramped;
                    status_next.right_vel     = right_ramped;
                    status_next.left_changed  = (left_goal_reg != left_cur_reg);
                    status_next.right_changed = (right_goal_reg != right_cur_reg);
                end
                ddm_pkg::FUNC_JOY:
                begin
                    left_goal_next  = ddm_pkg::mix_axis(axis_sum);
                    right_goal_next = ddm_pkg::mix_axis(axis_diff);
                end
                ddm_pkg::FUNC_DIRECT:
                begin
                    left_goal_next  = ddm_pkg::clamp_speed(10'(cmd.left_target));
                    right_goal_next = ddm_pkg::clamp_speed(10'(cmd.right_target));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_goal_reg  <= '0;
            right_goal_reg <= '0;
            left_cur_reg   <= '0;
            right_cur_reg  <= '0;
        end
        else
        begin
            left_goal_reg  <= left_goal_next;
            right_goal_reg <= right_goal_next;
            left_cur_reg   <= left_cur_next;
            right_cur_reg  <= right_cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign status = status_reg;

endmodule

// ===== hdl/ddm_duty.sv =====
// Two-stage H-bridge duty computation for one wheel: gain product, then scale and saturate.
module ddm_duty (
    input  logic            clk,
    input  logic            mul_en,
    input  logic            out_en,
    input  ddm_pkg::speed_t speed,
    input  logic [8:0]      gain,
    output logic [13:0]     fwd_duty,
    output logic [13:0]     rev_duty
);

    logic [16:0] prod_reg, prod_next;
    logic        neg_reg, neg_next;
    logic [13:0] fwd_reg, fwd_next;
    logic [13:0] rev_reg, rev_next;

    logic [7:0]  mag;
    logic [39:0] scaled;
    logic [15:0] quo;
    logic [13:0] duty;

    assign mag       = speed[7] ? 8'(-speed) : 8'(speed);
    assign prod_next = mul_en ? 17'(mag) * 17'(gain) : prod_reg;
    assign neg_next  = mul_en ? speed[7] : neg_reg;

    assign scaled = 40'(prod_reg) * 40'(ddm_pkg::DUTY_RECIP);
    assign quo    = scaled[39:24];
    assign duty   = (quo > 16'(ddm_pkg::DUTY_FULL)) ? ddm_pkg::DUTY_FULL : quo[13:0];

    assign fwd_next = out_en ? (neg_reg ? 14'd0 : duty) : fwd_reg;
    assign rev_next = out_en ? (neg_reg ? duty : 14'd0) : rev_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        fwd_reg  <= fwd_next;
        rev_reg  <= rev_next;
    end

    assign fwd_duty = fwd_reg;
    assign rev_duty = rev_reg;

endmodule

// ===== bench/drive_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks tick results of the drive mixer.
package drive_scoreboard_pkg;

    localparam int AXIS_FULL  = 32768;
    localparam int STEP_DIV   = 10;
    localparam int DUTY_NUM   = 32;
    localparam int DUTY_DEN   = 100;

    typedef struct {
        logic [13:0]     left_fwd;
        logic [13:0]     left_rev;
        logic [13:0]     right_fwd;
        logic [13:0]     right_rev;
        logic            left_moved;
        logic            right_moved;
        ddm_pkg::speed_t left_vel;
        ddm_pkg::speed_t right_vel;
    } tick_result_t;

    class drive_scoreboard;
        ddm_pkg::speed_t left_goal;
        ddm_pkg::speed_t right_goal;
        ddm_pkg::speed_t left_vel;
        ddm_pkg::speed_t right_vel;
        logic [8:0]      left_gain;
        logic [8:0]      right_gain;
        tick_result_t    expected_ticks[$];
        int              errors;
        int              ticks_checked;

        function new();
            left_goal     = '0;
            right_goal    = '0;
            left_vel      = '0;
            right_vel     = '0;
            left_gain     = 9'd256;
            right_gain    = 9'd256;
            errors        = 0;
            ticks_checked = 0;
        endfunction

        function void set_gain(input logic idx, input logic [8:0] value);
            if (idx == ddm_pkg::CFG_LEFT_GAIN)
            begin
                left_gain = value;
            end
            else
            begin
                right_gain = value;
            end
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function ddm_pkg::speed_t limit_speed(input int v);
            if (v > ddm_pkg::SPEED_MAX)
            begin
                return ddm_pkg::speed_t'(ddm_pkg::SPEED_MAX);
            end
            if (v < -ddm_pkg::SPEED_MAX)
            begin
                return ddm_pkg::speed_t'(-ddm_pkg::SPEED_MAX);
            end
            return ddm_pkg::speed_t'(v);
        endfunction

        // Integer division truncates toward zero, as the mixer requires.
        function ddm_pkg::speed_t scale_axis(input int a);
            return limit_speed((a * ddm_pkg::SPEED_MAX) / AXIS_FULL);
        endfunction

        function bit step_toward(input ddm_pkg::speed_t goal, inout ddm_pkg::speed_t cur);
            int d;
            int st;
            if (goal == cur)
            begin
                return 1'b0;
            end
            d  = int'(goal) - int'(cur);
            st = d / STEP_DIV;
            if (st == 0)
            begin
                st = (d > 0) ? 1 : -1;
            end
            cur = ddm_pkg::speed_t'(int'(cur) + st);
            return 1'b1;
        endfunction

        function logic [13:0] duty_of(input int mag, input logic [8:0] gain);
            int d;
            d = (mag * int'(gain) * DUTY_NUM) / DUTY_DEN;
            return (d > int'(ddm_pkg::DUTY_FULL)) ? ddm_pkg::DUTY_FULL : 14'(d);
        endfunction

        function void note_input(input ddm_pkg::cmd_t c);
            tick_result_t r;
            int           x;
            int           y;
            case (c.func)
                ddm_pkg::FUNC_JOY:
                begin
                    x          = int'($signed(c.stick_x));
                    y          = int'($signed(c.stick_y));
                    left_goal  = scale_axis(y + x);
                    right_goal = scale_axis(y - x);
                end
                ddm_pkg::FUNC_DIRECT:
                begin
                    left_goal  = limit_speed(int'($signed(c.left_target)));
                    right_goal = limit_speed(int'($signed(c.right_target)));
                end
                ddm_pkg::FUNC_TICK:
                begin
                    r.left_moved  = step_toward(left_goal, left_vel);
                    r.right_moved = step_toward(right_goal, right_vel);
                    r.left_vel    = left_vel;
                    r.right_vel   = right_vel;
                    r.left_fwd    = (left_vel >= 0) ? duty_of(int'(left_vel), left_gain) : '0;
                    r.left_rev    = (left_vel < 0) ? duty_of(-int'(left_vel), left_gain) : '0;
                    r.right_fwd   = (right_vel >= 0) ?
                                    duty_of(int'(right_vel), right_gain) : '0;
                    r.right_rev   = (right_vel < 0) ?
                                    duty_of(-int'(right_vel), right_gain) : '0;
                    expected_ticks.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(input logic [79:0] d);
            tick_result_t e;
            if (expected_ticks.size() == 0)
            begin
                errors++;
                $error("Result transaction with nothing expected: %h", d);
                return;
            end
            e = expected_ticks.pop_front();
            ticks_checked++;
            compare_field("left_fwd_duty", int'(e.left_fwd), int'(d[13:0]));
            compare_field("left_rev_duty", int'(e.left_rev), int'(d[27:14]));
            compare_field("right_fwd_duty", int'(e.right_fwd), int'(d[41:28]));
            compare_field("right_rev_duty", int'(e.right_rev), int'(d[55:42]));
            compare_field("left_changed", int'(e.left_moved), int'(d[56]));
            compare_field("right_changed", int'(e.right_moved), int'(d[57]));
            compare_field("left_speed_now", int'(e.left_vel), int'($signed(d[65:58])));
            compare_field("right_speed_now", int'(e.right_vel), int'($signed(d[73:66])));
        endfunction
    endclass

endpackage

// ===== bench/tb_diff_drive_mix_ramp_hbridge_pwm.sv =====
// Top-level testbench for the differential drive mixer with ramp and H-bridge duties.
module tb_diff_drive_mix_ramp_hbridge_pwm;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 128;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    drive_scoreboard_pkg::drive_scoreboard sb = new();

    bit tx_burst;
    bit hold_request;
    int cmds_sent;
    int cycles;

    diff_drive_mix_ramp_hbridge_pwm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic ddm_pkg::cmd_t make_cmd(input logic [1:0] func, input int x,
                                               input int y, input int lt, input int rt);
        ddm_pkg::cmd_t c;
        c.func         = func;
        c.stick_x      = 16'(x);
        c.stick_y      = 16'(y);
        c.left_target  = 8'(lt);
        c.right_target = 8'(rt);
        return c;
    endfunction

    function automatic int pick_axis();
        int choice;
        choice = $urandom_range(0, 7);
        case (choice)
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_target();
        if ($urandom_range(0, 1) == 0)
        begin
            return int'($urandom_range(0, 200)) - 100;
        end
        return int'($signed(8'($urandom)));
    endfunction

    function automatic ddm_pkg::cmd_t random_cmd();
        ddm_pkg::cmd_t c;
        int            roll;
        c    = make_cmd(ddm_pkg::FUNC_TICK, int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 62)
        begin
            c.func = ddm_pkg::FUNC_TICK;
        end
        else if (roll < 78)
        begin
            c.func    = ddm_pkg::FUNC_JOY;
            c.stick_x = 16'(pick_axis());
            c.stick_y = 16'(pick_axis());
        end
        else if (roll < 96)
        begin
            c.func         = ddm_pkg::FUNC_DIRECT;
            c.left_target  = 8'(pick_target());
            c.right_target = 8'(pick_target());
        end
        else
        begin
            c.func = FUNC_UNUSED;
        end
        return c;
    endfunction

    task automatic send_cmd(input ddm_pkg::cmd_t c);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = c.func;
        s_tdata  = {c.right_target, c.left_target, c.stick_y, c.stick_x};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_input(c);
        cmds_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_gain(input logic idx, input logic [8:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_gain(idx, value);
    endtask

    initial
    begin
        int waits;
        int results;
        bit rx_burst;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        results  = 0;
        @(posedge rst_n);
        forever
        begin
            if (results % 40 == 0)
            begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            waits = rx_burst ? 0 : $urandom_range(0, 8);
            if (hold_request)
            begin
                hold_request = 1'b0;
                waits        = LONG_HOLD;
            end
            if (waits > 0)
            begin
                m_tready = 1'b0;
                repeat (waits) @(negedge clk);
            end
            m_tready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            sb.check_result(m_tdata);
            results++;
            @(negedge clk);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding.", sb.pending());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [8:0] left_gains[PHASES];
        logic [8:0] right_gains[PHASES];
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ddm_pkg::FUNC_TICK;
        cfg_we       = 1'b0;
        cfg_index    = ddm_pkg::CFG_LEFT_GAIN;
        cfg_data     = '0;
        tx_burst     = 1'b0;
        hold_request = 1'b0;
        cmds_sent    = 0;
        left_gains   = '{9'd0, 9'd511, 9'd256, 9'd1, 9'd255, 9'd300, 9'd0, 9'd0, 9'd0, 9'd0};
        right_gains  = '{9'd511, 9'd0, 9'd256, 9'd255, 9'd1, 9'd128, 9'd0, 9'd0, 9'd0, 9'd0};
        for (int p = 6; p < PHASES; p++)
        begin
            left_gains[p]  = 9'($urandom);
            right_gains[p] = 9'($urandom);
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_DIRECT, $urandom, $urandom, 100, -100));
        repeat (3) send_cmd(make_cmd(ddm_pkg::FUNC_TICK, $urandom, $urandom, $urandom,
                                     $urandom));
        send_cmd(make_cmd(ddm_pkg::FUNC_DIRECT, 0, 0, 127, -128));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_JOY, 32767, 32767, $urandom, $urandom));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_JOY, -32768, -32768, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_JOY, -32768, 32767, -1, -1));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, -1, -1, -1, -1));
        send_cmd(make_cmd(ddm_pkg::FUNC_DIRECT, -1, -1, 1, -1));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_JOY, 0, 0, 127, -128));
        send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        send_cmd(make_cmd(ddm_pkg::FUNC_DIRECT, -1, -1, 0, 0));
        repeat (2) send_cmd(make_cmd(ddm_pkg::FUNC_TICK, 0, 0, 0, 0));
        stop_sending();
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            write_gain(ddm_pkg::CFG_LEFT_GAIN, left_gains[p]);
            write_gain(ddm_pkg::CFG_RIGHT_GAIN, right_gains[p]);
            // Stall the result side while ticks pour in, so the pipeline backs up.
            if (p == 3)
            begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                begin
                    tx_burst = (p == 3 && i == 0) || ($urandom_range(0, 3) == 0);
                end
                send_cmd((p == 3 && i < 40) ?
                         make_cmd(ddm_pkg::FUNC_TICK, $urandom, $urandom, $urandom, $urandom)
                         : random_cmd());
            end
            stop_sending();
            wait_drained();
        end

        $display("Accepted %0d command transactions and checked %0d tick results", cmds_sent,
                 sb.ticks_checked);
        $display("across %0d gain settings, with input bursts and a long output stall.",
                 PHASES + 1);
        if (sb.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
